/* hdl/stereo_crossfeed_filter_core_assert.svh */
// Assertion macros for the checker of the crossfeed core.
`ifndef STEREO_CROSSFEED_FILTER_CORE_ASSERT_SVH
`define STEREO_CROSSFEED_FILTER_CORE_ASSERT_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define SCF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked at the next rising clock edge.
`define SCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scf_pkg.sv */
`timescale 1ns / 1ps

package scf_pkg;

  // Field and arithmetic widths.
  localparam int SAMPLE_W  = 24;
  localparam int FRAC_W    = 25;
  localparam int COEFF_W   = FRAC_W + 2;
  localparam int STATE_W   = SAMPLE_W + 2;
  localparam int PROD_W    = 2 * COEFF_W;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam int ACC_W     = RND_W + 2;
  localparam int TDATA_W   = 2 * SAMPLE_W;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LO_DIR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LO_POLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HI_DIR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HI_PRIOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HI_POLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LO_DIR,
    ST_LO_POLE,
    ST_HI_DIR,
    ST_HI_PRIOR,
    ST_HI_POLE,
    ST_HI_STORE,
    ST_OUT_MUL,
    ST_OUT_STORE
  } scf_state_e;

  // Which coefficient and operand pair goes into the multipliers.
  typedef enum logic [2:0] {
    MUL_LO_DIR,
    MUL_LO_POLE,
    MUL_HI_DIR,
    MUL_HI_PRIOR,
    MUL_HI_POLE,
    MUL_OUT
  } scf_mul_sel_e;

  // What the accumulate stage does with the rounded product.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_STORE_LOW,
    ACC_STORE_HIGH,
    ACC_STORE_OUT
  } scf_acc_op_e;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic         in_load;
    scf_mul_sel_e mul_sel;
    scf_acc_op_e  acc_op;
  } scf_cmd_t;

  // Clamp an accumulator value to the filter state range.
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] vmax;
    logic signed [ACC_W-1:0] vmin;
    vmax = {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    vmin = {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    if (v > vmax) begin
      sat_state = vmax[STATE_W-1:0];
    end else if (v < vmin) begin
      sat_state = vmin[STATE_W-1:0];
    end else begin
      sat_state = v[STATE_W-1:0];
    end
  endfunction

  // Clamp a rounded product to the output sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] vmax;
    logic signed [RND_W-1:0] vmin;
    vmax = {{(RND_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    vmin = {{(RND_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
    if (v > vmax) begin
      sat_sample = vmax[SAMPLE_W-1:0];
    end else if (v < vmin) begin
      sat_sample = vmin[SAMPLE_W-1:0];
    end else begin
      sat_sample = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

/* hdl/scf_ctrl.sv */
`timescale 1ns / 1ps

module scf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scf_pkg::scf_cmd_t cmd_o
);
  import scf_pkg::*;

  scf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.in_load  = 1'b0;
    cmd_o.mul_sel  = MUL_LO_DIR;
    cmd_o.acc_op   = ACC_NONE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LO_DIR;
        end
      end
      ST_LO_DIR: begin
        cmd_o.mul_sel = MUL_LO_DIR;
        state_d       = ST_LO_POLE;
      end
      ST_LO_POLE: begin
        cmd_o.mul_sel = MUL_LO_POLE;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_HI_DIR;
      end
      ST_HI_DIR: begin
        cmd_o.mul_sel = MUL_HI_DIR;
        cmd_o.acc_op  = ACC_STORE_LOW;
        state_d       = ST_HI_PRIOR;
      end
      ST_HI_PRIOR: begin
        cmd_o.mul_sel = MUL_HI_PRIOR;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_HI_POLE;
      end
      ST_HI_POLE: begin
        cmd_o.mul_sel = MUL_HI_POLE;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_HI_STORE;
      end
      ST_HI_STORE: begin
        cmd_o.mul_sel = MUL_HI_POLE;
        cmd_o.acc_op  = ACC_STORE_HIGH;
        state_d       = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        cmd_o.mul_sel = MUL_OUT;
        state_d       = ST_OUT_STORE;
      end
      ST_OUT_STORE: begin
        // Operands are unchanged here, so the product holds while we wait.
        cmd_o.mul_sel = MUL_OUT;
        if (out_free) begin
          cmd_o.acc_op = ACC_STORE_OUT;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/scf_datapath.sv */
`timescale 1ns / 1ps

module scf_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scf_pkg::scf_cmd_t                     cmd_i,
  input  logic [scf_pkg::TDATA_W-1:0]           in_data_i,
  output logic [scf_pkg::TDATA_W-1:0]           out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [scf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [scf_pkg::COEFF_W-1:0]           cfg_data_i
);
  import scf_pkg::*;

  // Coefficient registers.
  logic signed [COEFF_W-1:0] lo_dir_q, lo_pole_q, hi_dir_q, hi_prior_q, hi_pole_q, out_gain_q;
  logic signed [COEFF_W-1:0] coeff_sel;
  logic                      cfg_hit;

  // Per-lane registers and nets; lane 0 is left, lane 1 is right.
  logic signed [SAMPLE_W-1:0] x_q     [2];
  logic signed [SAMPLE_W-1:0] prior_q [2];
  logic signed [STATE_W-1:0]  low_q   [2];
  logic signed [STATE_W-1:0]  high_q  [2];
  logic signed [PROD_W-1:0]   prod_q  [2];
  logic signed [PROD_W-1:0]   prod_d  [2];
  logic signed [ACC_W-1:0]    acc_q   [2];
  logic signed [SAMPLE_W-1:0] out_q   [2];
  logic signed [COEFF_W-1:0]  op_b    [2];
  logic signed [RND_W-1:0]    rnd     [2];
  logic signed [ACC_W-1:0]    rnd_ext [2];
  logic signed [ACC_W-1:0]    acc_sum [2];

  // A write to any defined register also clears the filter state.
  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_LO_DIR || cfg_idx_i == REG_LO_POLE ||
                                cfg_idx_i == REG_HI_DIR || cfg_idx_i == REG_HI_PRIOR ||
                                cfg_idx_i == REG_HI_POLE || cfg_idx_i == REG_OUT_GAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_dir_q   <= '0;
      lo_pole_q  <= '0;
      hi_dir_q   <= '0;
      hi_prior_q <= '0;
      hi_pole_q  <= '0;
      out_gain_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LO_DIR:   lo_dir_q   <= cfg_data_i;
        REG_LO_POLE:  lo_pole_q  <= cfg_data_i;
        REG_HI_DIR:   hi_dir_q   <= cfg_data_i;
        REG_HI_PRIOR: hi_prior_q <= cfg_data_i;
        REG_HI_POLE:  hi_pole_q  <= cfg_data_i;
        REG_OUT_GAIN: out_gain_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The coefficient is shared by both lanes.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LO_DIR:   coeff_sel = lo_dir_q;
      MUL_LO_POLE:  coeff_sel = lo_pole_q;
      MUL_HI_DIR:   coeff_sel = hi_dir_q;
      MUL_HI_PRIOR: coeff_sel = hi_prior_q;
      MUL_HI_POLE:  coeff_sel = hi_pole_q;
      MUL_OUT:      coeff_sel = out_gain_q;
      default:      coeff_sel = lo_dir_q;
    endcase
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    localparam int OTHER = 1 - g;

    // Operand select for this lane's multiplier.
    always_comb begin
      case (cmd_i.mul_sel)
        MUL_LO_DIR, MUL_HI_DIR: op_b[g] = COEFF_W'(x_q[g]);
        MUL_LO_POLE:            op_b[g] = COEFF_W'(low_q[g]);
        MUL_HI_PRIOR:           op_b[g] = COEFF_W'(prior_q[g]);
        MUL_HI_POLE:            op_b[g] = COEFF_W'(high_q[g]);
        MUL_OUT:                op_b[g] = COEFF_W'(high_q[g]) + COEFF_W'(low_q[OTHER]);
        default:                op_b[g] = COEFF_W'(x_q[g]);
      endcase
    end

    assign prod_d[g] = coeff_sel * op_b[g];

    // Round half up: arithmetic shift plus the first dropped bit.
    assign rnd[g]     = $signed(prod_q[g][PROD_W-1:FRAC_W])
                      + $signed({{(RND_W-1){1'b0}}, prod_q[g][FRAC_W-1]});
    assign rnd_ext[g] = ACC_W'(rnd[g]);
    assign acc_sum[g] = acc_q[g] + rnd_ext[g];

    // Payload registers: sample, product, accumulator and result.
    always_ff @(posedge clk_i) begin
      prod_q[g] <= prod_d[g];
      if (cmd_i.in_load) begin
        x_q[g] <= in_data_i[g*SAMPLE_W +: SAMPLE_W];
      end
      case (cmd_i.acc_op)
        ACC_LOAD:      acc_q[g] <= rnd_ext[g];
        ACC_ADD:       acc_q[g] <= acc_sum[g];
        ACC_STORE_OUT: out_q[g] <= sat_sample(rnd[g]);
        default: begin
        end
      endcase
    end

    // Filter state, cleared by reset and by configuration writes.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        low_q[g]   <= '0;
        high_q[g]  <= '0;
        prior_q[g] <= '0;
      end else if (cfg_hit) begin
        low_q[g]   <= '0;
        high_q[g]  <= '0;
        prior_q[g] <= '0;
      end else begin
        case (cmd_i.acc_op)
          ACC_STORE_LOW: low_q[g] <= sat_state(acc_sum[g]);
          ACC_STORE_HIGH: begin
            high_q[g]  <= sat_state(acc_sum[g]);
            prior_q[g] <= x_q[g];
          end
          default: begin
          end
        endcase
      end
    end

    assign out_data_o[g*SAMPLE_W +: SAMPLE_W] = out_q[g];
  end

endmodule

/* hdl/stereo_crossfeed_filter_core.sv */
`timescale 1ns / 1ps

// Stereo crossfeed filter core. Each request carries one frame (left and right
// signed 24-bit samples); each channel runs a first-order low-pass and a first-order
// high-pass with signed Q25 coefficients, and each output is the channel's own
// high-pass plus the other channel's low-pass times a Q25 gain, saturated to 24 bits.
// A frame keeps the core busy from its accept cycle until its result enters the
// output register. The work is six multiply steps on a two-lane 27x27 multiplier
// (one lane per channel) with a registered product and a round-and-accumulate stage
// behind it, plus one step that waits for the new high-pass state and one that rounds
// the final product into the output register. The next frame is taken once the result
// is in the output register, so the core takes no new frame while one is in work;
// a stalled result holds the core in its last step.
// Configuration writes are taken at any time but should be made while the core is
// idle; a write to any of the six registers also clears the filter state.
module stereo_crossfeed_filter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [scf_pkg::TDATA_W-1:0]   s_axis_tdata,   // left_in, right_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [scf_pkg::TDATA_W-1:0]   m_axis_tdata,   // left_out, right_out
  input  logic                          cfg_we_i,
  input  logic [scf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [scf_pkg::COEFF_W-1:0]   cfg_data_i
);
  import scf_pkg::*;

  scf_cmd_t cmd;

  scf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  scf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

/* hdl/scf_checker.sv */
`timescale 1ns / 1ps

`include "stereo_crossfeed_filter_core_assert.svh"

module scf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [scf_pkg::TDATA_W-1:0]   m_axis_tdata
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A result held back by the sink keeps its data.
  `SCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Once a frame is taken the core is busy until its result is stored.
  `SCF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready,
                   "request taken while busy")

  // The last sequencer step still blocks new requests.
  `SCF_ASSERT_IMPL(a_busy_to_store, clk_i, rst_ni, in_acc, ##8 !s_axis_tready,
                   "sequence shorter than expected")

  // A new result only appears as the sequencer finishes a frame.
  `SCF_ASSERT_IMPL(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid),
                   s_axis_tready && !$past(s_axis_tready), "result without a frame")

endmodule

bind stereo_crossfeed_filter_core scf_checker u_scf_checker (.*);
